>>> sv/mnst_pkg.sv
// ----------------------------------------------------------------------------
// mnst_pkg
// Shared types and constants of the MIDI note span tracker: item structs,
// the queued operation format and the fixed table geometry.
// ----------------------------------------------------------------------------
package mnst_pkg;

  // Table geometry: slot = channel * 128 + note
  localparam int NOTE_SLOTS = 2048;
  localparam int SLOT_W     = 11;
  localparam int NOTE_W     = 7;
  localparam int CHAN_W     = 4;
  localparam int VEL_W      = 8;
  localparam int FIELD_W    = 32;

  // Defaults for top-level parameters
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Reset value of the loop length register
  localparam logic [FIELD_W-1:0] LOOP_LENGTH_RST = 32'd48000;

  // Status high nibbles
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  // Command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  typedef struct packed {
    logic                command;
    logic [7:0]          status;
    logic [7:0]          data_one;
    logic [7:0]          data_two;
    logic [FIELD_W-1:0]  sample_offset;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  start_sample;
    logic [FIELD_W-1:0]  span_length;
    logic [CHAN_W-1:0]   channel;
    logic [NOTE_W-1:0]   note_number;
    logic [VEL_W-1:0]    velocity;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ON    = 2'd0,
    OP_OFF   = 2'd1,
    OP_CLOSE = 2'd2
  } op_kind_t;

  // Classified operation passed from front to back
  typedef struct packed {
    op_kind_t            kind;
    logic [SLOT_W-1:0]   slot;
    logic [FIELD_W-1:0]  when;
    logic [VEL_W-1:0]    vel;
  } op_t;

endpackage

>>> sv/mnst_ram.sv
// ----------------------------------------------------------------------------
// mnst_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mnst_front.sv
// ----------------------------------------------------------------------------
// mnst_front
// Front end: holds the loop length, accepts input items and classifies them
// into note-on, note-off and close operations; drops the rest.
// ----------------------------------------------------------------------------
module mnst_front #(
  parameter int TIME_WIDTH = mnst_pkg::TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  mnst_pkg::in_item_t in_item,
  input  logic               clearing,
  input  logic               q_full,
  output logic               push,
  output mnst_pkg::op_t      push_op
);

  import mnst_pkg::*;

  localparam logic [FIELD_W-1:0] TIME_MASK =
    FIELD_W'((64'd1 << TIME_WIDTH) - 64'd1);

  logic [FIELD_W-1:0] loop_length;
  logic [FIELD_W-1:0] loop_end;
  logic [FIELD_W-1:0] when;
  logic [3:0]         kind;
  logic               keep;
  op_kind_t           op_kind;

  // Loop length register
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= LOOP_LENGTH_RST;
    end else if (cfg_we) begin
      loop_length <= cfg_wdata;
    end
  end

  assign loop_end = loop_length & TIME_MASK;
  assign when     = in_item.sample_offset & TIME_MASK;
  assign kind     = in_item.status[7:4];

  // Classify the item; drop late events and other status bytes
  always_comb begin
    keep    = 1'b0;
    op_kind = OP_OFF;
    if (in_item.command == CMD_CLOSE) begin
      keep    = 1'b1;
      op_kind = OP_CLOSE;
    end else if (when < loop_end) begin
      if (kind == KIND_NOTE_ON && in_item.data_two != 8'd0) begin
        keep    = 1'b1;
        op_kind = OP_ON;
      end else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
        keep    = 1'b1;
        op_kind = OP_OFF;
      end
    end
  end

  assign in_stall = clearing | q_full;
  assign push     = in_valid & ~in_stall & keep;

  // Close ends at loop end; events end at their own time
  always_comb begin
    push_op.kind = op_kind;
    push_op.slot = {in_item.status[CHAN_W-1:0], in_item.data_one[NOTE_W-1:0]};
    push_op.when = (op_kind == OP_CLOSE) ? loop_end : when;
    push_op.vel  = in_item.data_two;
  end

endmodule

>>> sv/mnst_queue.sv
// ----------------------------------------------------------------------------
// mnst_queue
// Short FIFO of classified operations between front and back end.
// ----------------------------------------------------------------------------
module mnst_queue #(
  parameter int DEPTH = mnst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mnst_pkg::op_t push_op,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output mnst_pkg::op_t pop_op
);

  import mnst_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign pop_op  = slots[rd_ptr];

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/mnst_back.sv
// ----------------------------------------------------------------------------
// mnst_back
// Back end: clears the slot table after reset, then runs one table
// read-modify-write per operation with forwarding of the last write, and
// buffers finished spans in a two-entry output buffer.
// ----------------------------------------------------------------------------
module mnst_back #(
  parameter int TIME_WIDTH = mnst_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  output logic                clearing,
  input  logic                q_valid,
  input  mnst_pkg::op_t       q_op,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mnst_pkg::out_item_t out_item
);

  import mnst_pkg::*;

  // Entry: open flag, start sample, velocity
  localparam int ENTRY_W = 1 + TIME_WIDTH + VEL_W;

  logic [SLOT_W-1:0]     clr_addr;
  logic                  issue;
  logic                  room;
  logic [2:0]            avail;

  logic                  b_valid;
  op_t                   b_op;

  logic [ENTRY_W-1:0]    rdata;
  logic [ENTRY_W-1:0]    cur;
  logic                  last_valid;
  logic [SLOT_W-1:0]     last_slot;
  logic [ENTRY_W-1:0]    last_data;

  logic                  cur_open;
  logic [TIME_WIDTH-1:0] cur_start;
  logic [VEL_W-1:0]      cur_vel;
  logic [TIME_WIDTH-1:0] b_time;
  logic                  emit;
  logic [ENTRY_W-1:0]    upd;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;

  out_item_t             ob [2];
  logic                  ob_wr;
  logic                  ob_rd;
  logic [1:0]            ob_cnt;
  logic                  ob_push;
  logic                  ob_pop;
  out_item_t             span;

  // Clearing pass over all slots after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SLOT_W'(NOTE_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Issue only when the output buffer is sure to have space
  assign ob_pop = (ob_cnt != 2'd0) & ~out_stall;
  assign avail  = 3'(ob_cnt) + 3'(b_valid) - 3'(ob_pop);
  assign room   = (avail < 3'd2);
  assign issue  = q_valid & ~clearing & room;
  assign q_pop  = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_op <= q_op;
    end
  end

  // Slot table
  mnst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_op.slot),
    .rdata (rdata)
  );

  // Forward the most recent write when it hit the same slot
  assign cur = (last_valid && last_slot == b_op.slot) ? last_data : rdata;

  assign cur_open  = cur[ENTRY_W-1];
  assign cur_start = cur[ENTRY_W-2:VEL_W];
  assign cur_vel   = cur[VEL_W-1:0];
  assign b_time    = b_op.when[TIME_WIDTH-1:0];
  assign emit      = cur_open & (b_time > cur_start);

  // Note-on opens the slot; note-off and close shut it
  always_comb begin
    case (b_op.kind)
      OP_ON:    upd = {1'b1, b_time, b_op.vel};
      OP_OFF:   upd = {1'b0, cur_start, cur_vel};
      OP_CLOSE: upd = {1'b0, cur_start, cur_vel};
      default:  upd = cur;
    endcase
  end

  assign ram_we    = clearing | b_valid;
  assign ram_waddr = clearing ? clr_addr : b_op.slot;
  assign ram_wdata = clearing ? '0 : upd;

  // Track the last operation write
  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (b_valid) begin
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      last_slot <= b_op.slot;
      last_data <= upd;
    end
  end

  // Build the span
  always_comb begin
    span.start_sample = FIELD_W'(cur_start);
    span.span_length  = FIELD_W'(b_time - cur_start);
    span.channel      = b_op.slot[SLOT_W-1:NOTE_W];
    span.note_number  = b_op.slot[NOTE_W-1:0];
    span.velocity     = cur_vel;
  end

  assign ob_push = b_valid & emit;

  // Two-entry output buffer
  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob[ob_wr] <= span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wr <= ~ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= ~ob_rd;
      end
      if (ob_push && !ob_pop) begin
        ob_cnt <= ob_cnt + 2'd1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt <= ob_cnt - 2'd1;
      end
    end
  end

  assign out_valid = (ob_cnt != 2'd0);
  assign out_item  = ob[ob_rd];

endmodule

>>> sv/midi_note_span_tracker.sv
// ----------------------------------------------------------------------------
// midi_note_span_tracker
// Pairs time-ordered MIDI note-on and note-off events into note spans.
// ----------------------------------------------------------------------------
// After reset the block clears its slot table, with in_stall high
// (loop_length writes are taken during that time). It then accepts one
// item per cycle while in_stall is low: the front end classifies each
// item and drops late events and non-note status bytes, a small queue
// decouples it from the back end, and the back end does one
// read-modify-write of the 2048-entry slot table per note operation,
// forwarding its last write so that events on the same slot may follow
// each other in consecutive cycles. A span passes through the queue,
// the b_op stage register and the output buffer before it appears on
// out_valid. Write loop_length only while the block is idle.
// ----------------------------------------------------------------------------
module midi_note_span_tracker #(
  parameter int TIME_WIDTH  = mnst_pkg::TIME_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mnst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  mnst_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mnst_pkg::out_item_t out_item
);

  import mnst_pkg::*;

  logic clearing;
  logic q_full;
  logic push;
  op_t  push_op;
  logic q_valid;
  logic q_pop;
  op_t  q_op;

  // Accept and classify
  mnst_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  // Decouple front and back
  mnst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .pop_op  (q_op)
  );

  // Update the slot table and emit spans
  mnst_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
